// ===== rtl/core/itda_pkg.sv =====
package itda_pkg;

	localparam int VALUE_BITS = 32;

	// decimal digits in the largest magnitude, 2^(VALUE_BITS-1)
	function automatic int digit_count(input int bits);
		longint unsigned p;
		int n;
		p = longint'(1) << (bits - 1);
		n = 0;
		while (p != 0) begin
			p = p / 10;
			n++;
		end
		return n;
	endfunction

	localparam int NDIG   = digit_count(VALUE_BITS);
	localparam int BCD_W  = 4 * NDIG;
	localparam int IDX_W  = $clog2(NDIG);
	localparam int STEP_W = $clog2(VALUE_BITS);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [5:0] CH_ZERO  = 6'd48;
	localparam logic [5:0] CH_MINUS = 6'd45;

	typedef struct packed {
		logic                  neg;
		logic [VALUE_BITS-1:0] mag;
	} itda_item_t;

endpackage

// ===== rtl/core/itda_front.sv =====
module itda_front import itda_pkg::*; (
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [VALUE_BITS-1:0] s_tdata,  // [31:0] value
	input  logic                  q_full,
	output logic                  q_push,
	output itda_item_t            q_item
);

	logic sign;

	assign sign     = s_tdata[VALUE_BITS-1];
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// two's complement magnitude; the most negative value maps to 2^(VALUE_BITS-1)
	assign q_item.neg = sign;
	assign q_item.mag = sign ? (~s_tdata + VALUE_BITS'(1)) : s_tdata;

endmodule

// ===== rtl/core/itda_fifo.sv =====
module itda_fifo import itda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  itda_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output itda_item_t pop_item
);

	itda_item_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> $stable(wptr_q))
		else $error("write into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/core/itda_back.sv =====
module itda_back import itda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  itda_item_t q_item,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [5:0] char_code, [7:6] zero
	output logic       m_tlast   // last_char
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_LEAD = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [STEP_W-1:0]     step_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  sign_q;
	logic                  valid_q;
	logic [5:0]            char_q;
	logic                  last_q;

	logic [BCD_W-1:0]      dab;
	logic [IDX_W-1:0]      lead_idx;
	logic [3:0]            digs [NDIG];
	logic                  load;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			digs[i] = bcd_q[4*i +: 4];
			dab[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	// highest nonzero digit; zero keeps a single digit
	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				lead_idx = IDX_W'(i);
			end
		end
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign load  = (state_q == ST_EMIT) && (!valid_q || m_tready);

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, char_q};
	assign m_tlast  = last_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mag_q  <= q_item.mag;
				bcd_q  <= '0;
				step_q <= '0;
			end
			ST_CONV: begin
				bcd_q  <= {dab[BCD_W-2:0], mag_q[VALUE_BITS-1]};
				mag_q  <= mag_q << 1;
				step_q <= step_q + STEP_W'(1);
			end
			ST_LEAD: begin
				idx_q <= lead_idx;
			end
			ST_EMIT: begin
				if (load) begin
					if (sign_q) begin
						char_q <= CH_MINUS;
						last_q <= 1'b0;
					end else begin
						char_q <= CH_ZERO + {2'b00, digs[idx_q]};
						last_q <= (idx_q == '0);
						idx_q  <= idx_q - IDX_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sign_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (m_tready && !load) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						sign_q  <= q_item.neg;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (step_q == STEP_W'(VALUE_BITS - 1)) begin
						state_q <= ST_LEAD;
					end
				end
				ST_LEAD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						valid_q <= 1'b1;
						if (sign_q) begin
							sign_q <= 1'b0;
						end else if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		load && !sign_q && idx_q == '0 |=> state_q == ST_IDLE && m_tvalid && m_tlast)
		else $error("final digit did not close the item");
	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		load && sign_q |=> m_tvalid && !m_tlast && m_tdata[5:0] == CH_MINUS)
		else $error("minus sign not emitted first");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CONV |-> step_q <= STEP_W'(VALUE_BITS - 1))
		else $error("conversion step out of range");
`endif

endmodule

// ===== rtl/core/int_to_decimal_ascii_core.sv =====
// Signed integer to decimal ASCII. Each 32-bit two's complement word on the
// input stream becomes its decimal text on the output stream, one character per
// word, most significant digit first: a leading '-' for negative values, no
// leading zeros, a single '0' for zero, and tlast on the final character. The
// most negative value gives "-2147483648". A front stage takes the sign and
// magnitude and parks them in a two-entry queue, so input words are accepted
// while the back end is still busy. The back end converts one magnitude bit per
// cycle (shift-and-add-3 into BCD); for each item it takes the item from the
// queue, runs the conversion, finds the leading digit, then emits the characters
// (1 to 11), holding a character while the output is not ready. It takes the next
// item only after the final character of the current one is loaded.
module int_to_decimal_ascii_core import itda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [VALUE_BITS-1:0] s_tdata,  // [31:0] value
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,  // [5:0] char_code, [7:6] zero
	output logic                  m_tlast   // last_char
);

	itda_item_t push_item;
	itda_item_t pop_item;
	logic       push;
	logic       full;
	logic       pop;
	logic       not_empty;

	itda_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (full),
		.q_push   (push),
		.q_item   (push_item)
	);

	itda_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_item  (pop_item)
	);

	itda_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_item   (pop_item),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
